[hw/rtl/bdh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdh_pkg
// Shared types, codes and the command byte table of the button divert
// handshake engine.
// ----------------------------------------------------------------------------
package bdh_pkg;

    // Command length in bytes, zero padded past the header
    localparam int unsigned PAYLOAD_BYTES = 19;
    localparam int unsigned IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int unsigned CNT_W         = 5;

    // Protocol constants
    localparam logic [7:0] DEV_INDEX    = 8'hff;
    localparam logic [7:0] SW_ID        = 8'h02;
    localparam logic [7:0] ROOT_SLOT    = 8'h00;
    localparam logic [3:0] REPORTING_FN = 4'd3;
    localparam logic [7:0] ACK_CODE     = {REPORTING_FN, SW_ID[3:0]};
    localparam logic [7:0] DIVERT_ON    = 8'h03;
    localparam logic [7:0] DIVERT_OFF   = 8'h02;
    localparam logic [7:0] ERR_MARK     = 8'hff;
    localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;

    // Register map (byte address 4 * index)
    localparam int unsigned PADDR_W = 4;
    typedef enum logic [1:0] {
        REG_FWD_CID    = 2'd0,
        REG_FEATURE_ID = 2'd1,
        REG_SHORT_RID  = 2'd2,
        REG_LONG_RID   = 2'd3
    } t_reg_idx;

    // Event codes
    localparam logic [2:0] OP_CONNECT    = 3'd0;
    localparam logic [2:0] OP_DISCONNECT = 3'd1;
    localparam logic [2:0] OP_SET_WANTED = 3'd2;
    localparam logic [2:0] OP_OUT_ACCEPT = 3'd3;
    localparam logic [2:0] OP_REQUEST    = 3'd4;
    localparam logic [2:0] OP_REPORT     = 3'd5;

    // Result types
    localparam logic [1:0] RES_ACK     = 2'd0;
    localparam logic [1:0] RES_NOTHING = 2'd1;
    localparam logic [1:0] RES_CMD     = 2'd2;
    localparam logic [1:0] RES_VERDICT = 2'd3;

    // Command kinds, also used for the outstanding request
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_FEATURE = 2'd1;
    localparam logic [1:0] KIND_DIVERT  = 2'd2;

    // One result item
    typedef struct packed {
        logic [1:0] result_type;
        logic [1:0] out_kind;
        logic [7:0] out_rid;
        logic [7:0] out_byte;
        logic       out_last;
        logic       handled;
        logic       held_flip;
        logic       button_held;
        logic       claims_forward;
    } t_result;

    // Byte idx of a command; bytes past the six byte header are zero
    function automatic logic [7:0] cmd_byte(
        input logic [1:0]       kind,
        input logic [IDX_W-1:0] idx,
        input logic [15:0]      fid,
        input logic [15:0]      cid,
        input logic [7:0]       slot,
        input logic             enable
    );
        logic [7:0] b;
        b = 8'h00;
        if (kind == KIND_FEATURE) begin
            if (idx == IDX_W'(0)) b = DEV_INDEX;
            else if (idx == IDX_W'(1)) b = ROOT_SLOT;
            else if (idx == IDX_W'(2)) b = SW_ID;
            else if (idx == IDX_W'(3)) b = fid[15:8];
            else if (idx == IDX_W'(4)) b = fid[7:0];
        end else if (kind == KIND_DIVERT) begin
            if (idx == IDX_W'(0)) b = DEV_INDEX;
            else if (idx == IDX_W'(1)) b = slot;
            else if (idx == IDX_W'(2)) b = ACK_CODE;
            else if (idx == IDX_W'(3)) b = cid[15:8];
            else if (idx == IDX_W'(4)) b = cid[7:0];
            else if (idx == IDX_W'(5)) b = enable ? DIVERT_ON : DIVERT_OFF;
        end
        return b;
    endfunction

endpackage

[hw/rtl/bdh_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdh channel interfaces
// Event channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface bdh_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] rpt_id;
    logic [7:0] data_byte;
    logic       last;
    logic       desired;
    logic       accepted;
    logic [1:0] sent_kind;

    modport source (output valid, op, rpt_id, data_byte, last, desired,
                    accepted, sent_kind, input ready);
    modport sink   (input valid, op, rpt_id, data_byte, last, desired,
                    accepted, sent_kind, output ready);
endinterface

interface bdh_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_type;
    logic [1:0] out_kind;
    logic [7:0] out_rid;
    logic [7:0] out_byte;
    logic       out_last;
    logic       handled;
    logic       consumed;
    logic       held_flip;
    logic       button_held;
    logic       claims_forward;

    modport source (output valid, result_type, out_kind, out_rid, out_byte,
                    out_last, handled, consumed, held_flip, button_held,
                    claims_forward, input ready);
    modport sink   (input valid, result_type, out_kind, out_rid, out_byte,
                    out_last, handled, consumed, held_flip, button_held,
                    claims_forward, output ready);
endinterface

[hw/rtl/button_divert_handshake_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_divert_handshake_engine
// Host side of a vendor HID handshake that diverts one button: tracks the
// link and divert flags, emits get-feature / set-divert commands and judges
// incoming reports.
// ----------------------------------------------------------------------------
//  channel   dir  kind          carries
//  i_in      in   valid/ready   one event (op, report byte, flags)
//  o_out     out  valid/ready   one result (ack, command byte, verdict)
//  APB       in   psel/penable  register writes and reads, 4 registers
//
//  State updates at the accepting edge; the result lands in the output reg, so
//  events stream at 1 per cycle unless a command run or a stall holds them.
//  A command request produces PAYLOAD_BYTES command bytes, one per output
//  transfer; i_in.ready stays low until the final byte sits in the output reg.
//  Report bytes that are not last produce no result.
//  Reset (i_rst_n low, synchronous) clears all flags and loads register
//  defaults. Downstream stalls hold the output register and block new events.
// ----------------------------------------------------------------------------
module button_divert_handshake_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bdh_in_if.sink                      i_in,
    bdh_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bdh_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bdh_pkg::*;

    // Configuration registers
    logic [15:0] r_fwd_cid, r_feature_id;
    logic [7:0]  r_short_rid, r_long_rid;

    // Engine state
    logic             r_link_up, n_link_up;
    logic             r_wanted, n_wanted;
    logic             r_active, n_active;
    logic             r_held, n_held;
    logic             r_failed, n_failed;
    logic             r_pending, n_pending;
    logic [1:0]       r_awaiting, n_awaiting;
    logic [7:0]       r_slot, n_slot;
    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]       r_hdr [3];
    logic [7:0]       n_hdr [3];
    logic [7:0]       r_cid_hi, n_cid_hi;
    logic             r_scan_done, n_scan_done;
    logic             r_cid_found, n_cid_found;

    // Output register and command run tracking
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;
    logic             r_run, n_run;
    logic [IDX_W-1:0] r_emit_idx, n_emit_idx;

    logic in_xfer, out_xfer, cfg_wr;
    logic [1:0] reg_idx;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = r_out_valid && o_out.ready;
    assign i_in.ready = !r_run && (!r_out_valid || o_out.ready);

    // APB access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb begin
        unique case (reg_idx)
            REG_FWD_CID:    prdata = {16'h0000, r_fwd_cid};
            REG_FEATURE_ID: prdata = {16'h0000, r_feature_id};
            REG_SHORT_RID:  prdata = {24'h000000, r_short_rid};
            REG_LONG_RID:   prdata = {24'h000000, r_long_rid};
            default:        prdata = 32'h0;
        endcase
    end

    // Event processing and result selection
    always_comb begin
        logic             res;
        logic [IDX_W-1:0] nxt;
        logic [CNT_W-1:0] idx;
        logic [15:0]      cid;
        logic             base, done, hnd, chg, ev_held;
        logic [1:0]       kind;

        n_link_up    = r_link_up;
        n_wanted     = r_wanted;
        n_active     = r_active;
        n_held       = r_held;
        n_failed     = r_failed;
        n_pending    = r_pending;
        n_awaiting   = r_awaiting;
        n_slot       = r_slot;
        n_byte_count = r_byte_count;
        n_hdr        = r_hdr;
        n_cid_hi     = r_cid_hi;
        n_scan_done  = r_scan_done;
        n_cid_found  = r_cid_found;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_run        = r_run;
        n_emit_idx   = r_emit_idx;
        res  = 1'b1;
        kind = KIND_NONE;
        hnd  = 1'b0;
        chg  = 1'b0;
        base = 1'b0;
        done = 1'b0;
        ev_held = 1'b0;
        idx  = r_byte_count;
        cid  = {r_cid_hi, i_in.data_byte};
        nxt  = IDX_W'(r_emit_idx + IDX_W'(1));

        if (in_xfer) begin
            // connect / disconnect reset everything but the wanted flag
            if (i_in.op == OP_CONNECT || i_in.op == OP_DISCONNECT) begin
                n_link_up    = (i_in.op == OP_CONNECT);
                n_active     = 1'b0;
                n_held       = 1'b0;
                n_failed     = 1'b0;
                n_pending    = 1'b0;
                n_awaiting   = KIND_NONE;
                n_slot       = 8'h00;
                n_byte_count = '0;
                n_hdr        = '{default: 8'h00};
                n_cid_hi     = 8'h00;
                n_scan_done  = 1'b0;
                n_cid_found  = 1'b0;
            end else if (i_in.op == OP_SET_WANTED) begin
                if (i_in.desired != r_wanted) begin
                    n_wanted = i_in.desired;
                    if (i_in.desired) n_failed = 1'b0;
                end
            end else if (i_in.op == OP_OUT_ACCEPT) begin
                if (i_in.accepted &&
                    (i_in.sent_kind == KIND_FEATURE || i_in.sent_kind == KIND_DIVERT))
                    n_awaiting = i_in.sent_kind;
            end else if (i_in.op == OP_REQUEST) begin
                // pick the next command, if any
                if (r_link_up && r_awaiting == KIND_NONE) begin
                    if (r_slot == 8'h00) begin
                        if (r_wanted && !r_failed) kind = KIND_FEATURE;
                    end else if (r_active != r_wanted) begin
                        kind      = KIND_DIVERT;
                        n_pending = r_wanted;
                    end
                end
            end else if (i_in.op == OP_REPORT) begin
                // assemble header and scan the control-id list
                if (idx != COUNT_MAX) begin
                    if (idx == CNT_W'(1)) n_hdr[0] = i_in.data_byte;
                    if (idx == CNT_W'(2)) n_hdr[1] = i_in.data_byte;
                    if (idx == CNT_W'(3)) n_hdr[2] = i_in.data_byte;
                    if (idx >= CNT_W'(3) && !r_scan_done) begin
                        if (idx[0]) begin
                            n_cid_hi = i_in.data_byte;
                        end else if (cid == 16'h0000) begin
                            n_scan_done = 1'b1;
                        end else if (cid == r_fwd_cid) begin
                            n_cid_found = 1'b1;
                        end
                    end
                    n_byte_count = CNT_W'(idx + CNT_W'(1));
                end
                res = i_in.last;
                if (i_in.last) begin
                    // judge the finished report
                    base = r_link_up &&
                           (i_in.rpt_id == r_short_rid || i_in.rpt_id == r_long_rid) &&
                           (r_wanted || r_active || r_awaiting != KIND_NONE ||
                            r_slot != 8'h00);
                    if (base) begin
                        hnd = 1'b1;
                        if (r_awaiting == KIND_FEATURE) begin
                            if (n_byte_count >= CNT_W'(5) && n_hdr[0] == ERR_MARK &&
                                n_hdr[1] == ROOT_SLOT && n_hdr[2] == SW_ID) begin
                                n_failed   = 1'b1;
                                n_awaiting = KIND_NONE;
                                done       = 1'b1;
                            end else if (n_byte_count >= CNT_W'(4) &&
                                         n_hdr[0] == ROOT_SLOT && n_hdr[1] == SW_ID) begin
                                n_slot     = n_hdr[2];
                                n_failed   = (n_hdr[2] == 8'h00);
                                n_awaiting = KIND_NONE;
                                done       = 1'b1;
                            end
                        end
                        if (!done && r_awaiting == KIND_DIVERT) begin
                            if (n_byte_count >= CNT_W'(5) && n_hdr[0] == ERR_MARK &&
                                n_hdr[1] == r_slot && n_hdr[2] == ACK_CODE) begin
                                if (r_pending) begin
                                    n_failed = 1'b1;
                                    n_active = 1'b0;
                                end
                                n_awaiting = KIND_NONE;
                                done       = 1'b1;
                            end else if (n_byte_count >= CNT_W'(3) &&
                                         n_hdr[0] == r_slot && n_hdr[1] == ACK_CODE) begin
                                n_active = r_pending;
                                if (!r_pending) n_held = 1'b0;
                                chg        = r_held && !r_pending;
                                n_awaiting = KIND_NONE;
                                done       = 1'b1;
                            end
                        end
                        // button event report
                        if (!done && r_slot != 8'h00 && n_byte_count >= CNT_W'(3) &&
                            n_hdr[0] == r_slot && n_hdr[1][7:4] == 4'h0) begin
                            ev_held = n_cid_found && r_active;
                            if (ev_held != r_held) begin
                                n_held = ev_held;
                                chg    = 1'b1;
                            end
                        end
                    end
                    // report done: drop the assembly
                    n_byte_count = '0;
                    n_hdr        = '{default: 8'h00};
                    n_cid_hi     = 8'h00;
                    n_scan_done  = 1'b0;
                    n_cid_found  = 1'b0;
                end
            end

            // load the result register
            if (res) begin
                n_out_valid          = 1'b1;
                n_out                = '0;
                n_out.button_held    = n_held;
                n_out.claims_forward = n_link_up && n_active;
                n_run                = 1'b0;
                n_emit_idx           = '0;
                if (i_in.op == OP_REQUEST) begin
                    if (kind == KIND_NONE) begin
                        n_out.result_type = RES_NOTHING;
                    end else begin
                        n_out.result_type = RES_CMD;
                        n_out.out_kind    = kind;
                        n_out.out_rid     = r_long_rid;
                        n_out.out_byte    = cmd_byte(kind, '0, r_feature_id, r_fwd_cid,
                                                     r_slot, n_pending);
                        n_run             = 1'b1;
                    end
                end else if (i_in.op == OP_REPORT) begin
                    n_out.result_type = RES_VERDICT;
                    n_out.handled     = hnd;
                    n_out.held_flip   = chg;
                end else begin
                    n_out.result_type = RES_ACK;
                end
            end else if (out_xfer) begin
                n_out_valid = 1'b0;
            end
        end else if (out_xfer) begin
            if (r_run) begin
                // next byte of the command run
                n_emit_idx     = nxt;
                n_out.out_byte = cmd_byte(r_out.out_kind, nxt, r_feature_id, r_fwd_cid,
                                          r_slot, r_pending);
                n_out.out_last = (nxt == IDX_W'(PAYLOAD_BYTES - 1));
                n_run          = (nxt != IDX_W'(PAYLOAD_BYTES - 1));
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_cid    <= 16'd0;
            r_feature_id <= 16'd6916;
            r_short_rid  <= 8'd16;
            r_long_rid   <= 8'd17;
            r_link_up    <= 1'b0;
            r_wanted     <= 1'b0;
            r_active     <= 1'b0;
            r_held       <= 1'b0;
            r_failed     <= 1'b0;
            r_pending    <= 1'b0;
            r_awaiting   <= KIND_NONE;
            r_slot       <= 8'h00;
            r_byte_count <= '0;
            r_hdr        <= '{default: 8'h00};
            r_cid_hi     <= 8'h00;
            r_scan_done  <= 1'b0;
            r_cid_found  <= 1'b0;
            r_out_valid  <= 1'b0;
            r_run        <= 1'b0;
            r_emit_idx   <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (reg_idx)
                    REG_FWD_CID:    r_fwd_cid    <= pwdata[15:0];
                    REG_FEATURE_ID: r_feature_id <= pwdata[15:0];
                    REG_SHORT_RID:  r_short_rid  <= pwdata[7:0];
                    REG_LONG_RID:   r_long_rid   <= pwdata[7:0];
                    default: ;
                endcase
            end
            r_link_up    <= n_link_up;
            r_wanted     <= n_wanted;
            r_active     <= n_active;
            r_held       <= n_held;
            r_failed     <= n_failed;
            r_pending    <= n_pending;
            r_awaiting   <= n_awaiting;
            r_slot       <= n_slot;
            r_byte_count <= n_byte_count;
            r_hdr        <= n_hdr;
            r_cid_hi     <= n_cid_hi;
            r_scan_done  <= n_scan_done;
            r_cid_found  <= n_cid_found;
            r_out_valid  <= n_out_valid;
            r_run        <= n_run;
            r_emit_idx   <= n_emit_idx;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_type    = r_out.result_type;
    assign o_out.out_kind       = r_out.out_kind;
    assign o_out.out_rid        = r_out.out_rid;
    assign o_out.out_byte       = r_out.out_byte;
    assign o_out.out_last       = r_out.out_last;
    assign o_out.handled        = r_out.handled;
    assign o_out.consumed       = r_out.handled;
    assign o_out.held_flip      = r_out.held_flip;
    assign o_out.button_held    = r_out.button_held;
    assign o_out.claims_forward = r_out.claims_forward;

endmodule

[sim/bdh_divert_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdh_divert_checker
// Watches the event channel, the result channel and register writes of the
// button divert handshake engine. Keeps its own copy of the link, divert and
// held flags, predicts the results of every accepted event and compares each
// result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bdh_divert_checker
    import bdh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    bdh_in_if                  in_mon,
    bdh_out_if                 out_mon,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fail_count,
    output int                 pending,
    output int                 n_results,
    output int                 n_verdicts,
    output int                 n_held_changes
);

    // Register copies
    logic [15:0] cfg_cid;
    logic [15:0] cfg_fid;
    logic [7:0]  cfg_srid;
    logic [7:0]  cfg_lrid;

    // Engine state copy
    logic       link_up;
    logic       fwd_wanted;
    logic       fwd_active;
    logic       held;
    logic       feat_failed;
    logic       enable_pending;
    logic [1:0] awaiting;
    logic [7:0] slot;
    logic [4:0] byte_cnt;
    logic [7:0] hdr [0:2];
    logic [7:0] cid_hi;
    logic       scan_done;
    logic       cid_found;

    t_result expected_results [$];
    int      fails    = 0;
    int      checked  = 0;
    int      verdicts = 0;
    int      held_chg = 0;

    task automatic clear_report();
        byte_cnt  = '0;
        foreach (hdr[i]) hdr[i] = 8'h00;
        cid_hi    = 8'h00;
        scan_done = 1'b0;
        cid_found = 1'b0;
    endtask

    // Link change: everything but the wanted flag goes back to reset
    task automatic drop_link();
        link_up        = 1'b0;
        fwd_active     = 1'b0;
        held           = 1'b0;
        feat_failed    = 1'b0;
        enable_pending = 1'b0;
        awaiting       = KIND_NONE;
        slot           = 8'h00;
        clear_report();
    endtask

    task automatic push_result(input logic [1:0] rtype, input logic [1:0] kind,
                               input logic [7:0] rid, input logic [7:0] b,
                               input logic lst, input logic hnd, input logic hc);
        t_result r;
        r.result_type    = rtype;
        r.out_kind       = kind;
        r.out_rid        = rid;
        r.out_byte       = b;
        r.out_last       = lst;
        r.handled        = hnd;
        r.held_flip      = hc;
        r.button_held    = held;
        r.claims_forward = link_up && fwd_active;
        expected_results.push_back(r);
    endtask

    // Next command: get-feature until a slot is known, then set-divert
    task automatic predict_request();
        logic [1:0] kind;
        logic [7:0] head [0:5];
        if (link_up && awaiting == KIND_NONE && slot == 8'h00
                && fwd_wanted && !feat_failed) begin
            kind = KIND_FEATURE;
            head = '{DEV_INDEX, ROOT_SLOT, SW_ID, cfg_fid[15:8], cfg_fid[7:0], 8'h00};
        end else if (link_up && awaiting == KIND_NONE && slot != 8'h00
                && fwd_active != fwd_wanted) begin
            kind           = KIND_DIVERT;
            enable_pending = fwd_wanted;
            head = '{DEV_INDEX, slot, ACK_CODE, cfg_cid[15:8], cfg_cid[7:0],
                     fwd_wanted ? DIVERT_ON : DIVERT_OFF};
        end else begin
            kind = KIND_NONE;
        end
        if (kind == KIND_NONE) begin
            push_result(RES_NOTHING, KIND_NONE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        end else begin
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                push_result(RES_CMD, kind, cfg_lrid, (i < 6) ? head[i] : 8'h00,
                            i == PAYLOAD_BYTES - 1, 1'b0, 1'b0);
            end
        end
    endtask

    // Verdict on a finished report; updates flags, returns handled
    function automatic logic judge_report(input logic [7:0] rid, input logic [4:0] len,
                                          output logic changed);
        logic was_held;
        logic now_held;
        changed = 1'b0;
        if (!link_up || (rid != cfg_srid && rid != cfg_lrid)) return 1'b0;
        if (!(fwd_wanted || fwd_active || awaiting != KIND_NONE || slot != 8'h00))
            return 1'b0;
        if (awaiting == KIND_FEATURE) begin
            if (len >= 5 && hdr[0] == ERR_MARK && hdr[1] == ROOT_SLOT
                    && hdr[2] == SW_ID) begin
                feat_failed = 1'b1;
                awaiting    = KIND_NONE;
                return 1'b1;
            end
            if (len >= 4 && hdr[0] == ROOT_SLOT && hdr[1] == SW_ID) begin
                slot        = hdr[2];
                feat_failed = (hdr[2] == 8'h00);
                awaiting    = KIND_NONE;
                return 1'b1;
            end
        end
        if (awaiting == KIND_DIVERT) begin
            if (len >= 5 && hdr[0] == ERR_MARK && hdr[1] == slot
                    && hdr[2] == ACK_CODE) begin
                if (enable_pending) begin
                    feat_failed = 1'b1;
                    fwd_active  = 1'b0;
                end
                awaiting = KIND_NONE;
                return 1'b1;
            end
            if (len >= 3 && hdr[0] == slot && hdr[1] == ACK_CODE) begin
                was_held   = held;
                fwd_active = enable_pending;
                if (!fwd_active) held = 1'b0;
                awaiting = KIND_NONE;
                changed  = (was_held != held);
                return 1'b1;
            end
        end
        // Button event: held follows whether our control id was listed
        if (slot != 8'h00 && len >= 3 && hdr[0] == slot && hdr[1][7:4] == 4'h0) begin
            now_held = cid_found && fwd_active;
            if (now_held != held) begin
                held    = now_held;
                changed = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    task automatic take_report_byte(input logic [7:0] rid, input logic [7:0] data,
                                    input logic lst);
        logic [4:0] idx;
        logic       hnd;
        logic       hc;
        idx = byte_cnt;
        if (idx < COUNT_MAX) begin
            if (idx >= 1 && idx <= 3) hdr[idx - 1] = data;
            // control-id list: pairs from byte 3, zero id ends it
            if (idx >= 3 && !scan_done) begin
                if (idx[0]) cid_hi = data;
                else if ({cid_hi, data} == 16'h0000) scan_done = 1'b1;
                else if ({cid_hi, data} == cfg_cid) cid_found = 1'b1;
            end
            byte_cnt = idx + 5'd1;
        end
        if (lst) begin
            hnd = judge_report(rid, byte_cnt, hc);
            clear_report();
            push_result(RES_VERDICT, KIND_NONE, 8'h00, 8'h00, 1'b0, hnd, hc);
        end
    endtask

    task automatic predict_event(input logic [2:0] op, input logic [7:0] rid,
                                 input logic [7:0] data, input logic lst,
                                 input logic desired, input logic accepted,
                                 input logic [1:0] kind);
        logic give_ack;
        give_ack = 1'b1;
        case (op)
            OP_CONNECT: begin
                drop_link();
                link_up = 1'b1;
            end
            OP_DISCONNECT: drop_link();
            OP_SET_WANTED: begin
                if (desired != fwd_wanted) begin
                    fwd_wanted = desired;
                    if (desired) feat_failed = 1'b0;
                end
            end
            OP_OUT_ACCEPT: begin
                if (accepted && (kind == KIND_FEATURE || kind == KIND_DIVERT))
                    awaiting = kind;
            end
            OP_REQUEST: begin
                give_ack = 1'b0;
                predict_request();
            end
            OP_REPORT: begin
                give_ack = 1'b0;
                take_report_byte(rid, data, lst);
            end
            default: ;
        endcase
        if (give_ack) push_result(RES_ACK, KIND_NONE, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: result %0d field %s mismatch, expected %0h, actual %0h",
                     $time, checked, name, want, got);
            fails++;
        end
    endtask

    task automatic check_result(input t_result want);
        check_field("result_type", 8'(want.result_type), 8'(out_mon.result_type));
        check_field("out_kind", 8'(want.out_kind), 8'(out_mon.out_kind));
        check_field("out_rid", want.out_rid, out_mon.out_rid);
        check_field("out_byte", want.out_byte, out_mon.out_byte);
        check_field("out_last", 8'(want.out_last), 8'(out_mon.out_last));
        check_field("handled", 8'(want.handled), 8'(out_mon.handled));
        check_field("consumed", 8'(want.handled), 8'(out_mon.consumed));
        check_field("held_flip", 8'(want.held_flip), 8'(out_mon.held_flip));
        check_field("button_held", 8'(want.button_held), 8'(out_mon.button_held));
        check_field("claims_forward", 8'(want.claims_forward),
                    8'(out_mon.claims_forward));
        if (want.result_type == RES_VERDICT) verdicts++;
        if (want.held_flip) held_chg++;
        checked++;
    endtask

    // Result transfers are checked before the same edge's event is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_cid    = 16'd0;
            cfg_fid    = 16'd6916;
            cfg_srid   = 8'd16;
            cfg_lrid   = 8'd17;
            fwd_wanted = 1'b0;
            drop_link();
            expected_results.delete();
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer, expected none, actual type %0d",
                             $time, out_mon.result_type);
                    fails++;
                end else begin
                    check_result(expected_results.pop_front());
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[PADDR_W-1:2]))
                    REG_FWD_CID:    cfg_cid  = pwdata[15:0];
                    REG_FEATURE_ID: cfg_fid  = pwdata[15:0];
                    REG_SHORT_RID:  cfg_srid = pwdata[7:0];
                    REG_LONG_RID:   cfg_lrid = pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready) begin
                predict_event(in_mon.op, in_mon.rpt_id, in_mon.data_byte, in_mon.last,
                              in_mon.desired, in_mon.accepted, in_mon.sent_kind);
            end
        end
        fail_count     <= fails;
        pending        <= expected_results.size();
        n_results      <= checked;
        n_verdicts     <= verdicts;
        n_held_changes <= held_chg;
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the button divert handshake engine with a directed handshake, then
// random handshakes, button event reports, broken reports and noise over four
// register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import bdh_pkg::*;

    localparam int         HOLD_CYCLES = 160;
    localparam int         LIMIT       = 400000;
    localparam logic [2:0] OP_SPARE_6  = 3'd6;
    localparam logic [2:0] OP_SPARE_7  = 3'd7;
    localparam logic [1:0] KIND_SPARE  = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    bdh_in_if  in_if ();
    bdh_out_if out_if ();

    int fails;
    int pending;
    int n_results;
    int n_verdicts;
    int n_held;
    int n_events  = 0;
    int cycle_cnt = 0;
    bit no_gaps   = 1'b0;
    bit hold_req  = 1'b0;

    // What the stimulus believes about the engine, to aim reports
    logic [15:0] tb_cid;
    logic [7:0]  tb_slot;
    logic [7:0]  tb_srid;
    logic [7:0]  tb_lrid;
    logic [7:0]  rpt_buf [0:39];
    int          rpt_len;

    button_divert_handshake_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bdh_divert_checker divert_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .in_mon         (in_if),
        .out_mon        (out_if),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .fail_count     (fails),
        .pending        (pending),
        .n_results      (n_results),
        .n_verdicts     (n_verdicts),
        .n_held_changes (n_held)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        while (cycle_cnt < LIMIT) @(posedge i_clk) cycle_cnt++;
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
        $display("Some tests failed");
        $finish;
    end

    // Result receiver: random ready stretches, one requested long hold-off
    initial begin
        int  run_left;
        bit  rdy;
        run_left = 0;
        rdy      = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (run_left != 0) begin
                run_left--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                rdy      = 1'b0;
                run_left = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                rdy = !rdy;
                if (rdy) run_left = ($urandom_range(0, 15) == 0) ? 150 : $urandom_range(0, 12);
                else run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                             : $urandom_range(0, 2);
                out_if.ready <= rdy;
            end
        end
    end

    // One event transfer, after a random gap
    task automatic drive(input logic [2:0] op, input logic [7:0] rid, input logic [7:0] data,
                         input logic lst, input logic desired, input logic accepted,
                         input logic [1:0] kind);
        int gap;
        int pick;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 60) gap = 0;
        else if (pick < 93) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.rpt_id    <= rid;
        in_if.data_byte <= data;
        in_if.last      <= lst;
        in_if.desired   <= desired;
        in_if.accepted  <= accepted;
        in_if.sent_kind <= kind;
        do @(posedge i_clk); while (!in_if.ready);
        n_events++;
    endtask

    // Control event; fields it does not use carry random values
    task automatic ctl(input logic [2:0] op, input logic desired, input logic accepted,
                       input logic [1:0] kind);
        drive(op, 8'($urandom), 8'($urandom), 1'($urandom), desired, accepted, kind);
    endtask

    task automatic simple(input logic [2:0] op);
        ctl(op, 1'($urandom), 1'($urandom), 2'($urandom));
    endtask

    // Sends the first n bytes of the report buffer
    task automatic send_report(input logic [7:0] rid, input int n);
        for (int i = 0; i < n; i++) begin
            drive(OP_REPORT, rid, rpt_buf[i], i == rpt_len - 1, 1'($urandom),
                  1'($urandom), 2'($urandom));
        end
    endtask

    task automatic set_head(input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3,
                            input int len);
        rpt_buf[0] = 8'($urandom);
        rpt_buf[1] = b1;
        rpt_buf[2] = b2;
        rpt_buf[3] = b3;
        for (int i = 4; i < len; i++) rpt_buf[i] = 8'($urandom);
        rpt_len = len;
    endtask

    // Button event report with a control-id list; a few run past the count limit
    task automatic build_button(input bit hit);
        int          npairs;
        int          at;
        int          pos;
        logic [15:0] cid;
        rpt_buf[0] = 8'($urandom);
        rpt_buf[1] = ($urandom_range(0, 7) != 0) ? tb_slot : 8'($urandom);
        rpt_buf[2] = ($urandom_range(0, 4) != 0) ? {4'h0, 4'($urandom)} : 8'($urandom);
        npairs = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 16) : $urandom_range(0, 5);
        at  = $urandom_range(0, npairs);
        pos = 3;
        for (int p = 0; p < npairs; p++) begin
            cid = (hit && p == at) ? tb_cid : 16'($urandom);
            rpt_buf[pos]     = cid[15:8];
            rpt_buf[pos + 1] = cid[7:0];
            pos += 2;
        end
        if ($urandom_range(0, 1) != 0) begin
            rpt_buf[pos]     = 8'h00;
            rpt_buf[pos + 1] = 8'h00;
            pos += 2;
        end
        rpt_len = pos;
    endtask

    function automatic logic [7:0] pick_rid();
        int p;
        p = $urandom_range(0, 19);
        if (p < 9) return tb_srid;
        if (p < 18) return tb_lrid;
        return 8'($urandom);
    endfunction

    // Setup and access phases, then the bus goes idle
    task automatic reg_write(input t_reg_idx idx, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] cid, input logic [15:0] fid,
                              input logic [7:0] srid, input logic [7:0] lrid);
        reg_write(REG_FWD_CID, cid);
        reg_write(REG_FEATURE_ID, fid);
        reg_write(REG_SHORT_RID, 16'(srid));
        reg_write(REG_LONG_RID, 16'(lrid));
        tb_cid  = cid;
        tb_srid = srid;
        tb_lrid = lrid;
    endtask

    // Wait until every predicted result has been seen, then a short tail
    task automatic settle(input int extra);
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // Full handshake: connect, get-feature, set-divert, with reply variants
    task automatic handshake();
        int v;
        simple(OP_CONNECT);
        ctl(OP_SET_WANTED, 1'b1, 1'($urandom), 2'($urandom));
        simple(OP_REQUEST);
        ctl(OP_OUT_ACCEPT, 1'($urandom), 1'b1, KIND_FEATURE);
        v = $urandom_range(0, 19);
        if (v < 13) begin
            tb_slot = 8'($urandom_range(1, 255));
            set_head(ROOT_SLOT, SW_ID, tb_slot, $urandom_range(4, 7));
        end else if (v < 15) begin
            tb_slot = 8'h00;
            set_head(ROOT_SLOT, SW_ID, 8'h00, 4);
        end else if (v < 17) begin
            tb_slot = 8'h00;
            set_head(ERR_MARK, ROOT_SLOT, SW_ID, 5);
        end else begin
            tb_slot = 8'h00;
            set_head(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(1, 6));
        end
        send_report(pick_rid(), rpt_len);
        simple(OP_REQUEST);
        ctl(OP_OUT_ACCEPT, 1'($urandom), 1'b1, KIND_DIVERT);
        v = $urandom_range(0, 9);
        if (v < 7) set_head(tb_slot, ACK_CODE, 8'($urandom), $urandom_range(3, 4));
        else if (v < 8) set_head(ERR_MARK, tb_slot, ACK_CODE, 5);
        else set_head(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(1, 6));
        send_report(pick_rid(), rpt_len);
        build_button(1'b1);
        send_report(pick_rid(), rpt_len);
    endtask

    task automatic run_scenario();
        int pick;
        pick    = $urandom_range(0, 99);
        no_gaps = ($urandom_range(0, 3) == 0);
        if (pick < 22) begin
            handshake();
        end else if (pick < 50) begin
            build_button($urandom_range(0, 9) < 6);
            send_report(pick_rid(), rpt_len);
        end else if (pick < 58) begin
            // turn the divert off again
            ctl(OP_SET_WANTED, 1'b0, 1'($urandom), 2'($urandom));
            simple(OP_REQUEST);
            ctl(OP_OUT_ACCEPT, 1'($urandom), 1'b1, KIND_DIVERT);
            set_head(tb_slot, ACK_CODE, 8'($urandom), 3);
            send_report(pick_rid(), rpt_len);
        end else if (pick < 72) begin
            drive(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom), 2'($urandom));
        end else if (pick < 82) begin
            set_head(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(1, 6));
            send_report(pick_rid(), rpt_len);
        end else if (pick < 88) begin
            simple(OP_REQUEST);
            simple(OP_OUT_ACCEPT);
        end else begin
            // link change in the middle of a report
            build_button(1'b1);
            send_report(pick_rid(), $urandom_range(1, rpt_len - 1 > 1 ? rpt_len - 1 : 1));
            simple(($urandom_range(0, 1) != 0) ? OP_CONNECT : OP_DISCONNECT);
        end
        no_gaps = 1'b0;
    endtask

    task automatic random_phase(input int upto);
        while (n_events < upto) run_scenario();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_if.valid     <= 1'b0;
        in_if.op        <= OP_CONNECT;
        in_if.rpt_id    <= 8'h00;
        in_if.data_byte <= 8'h00;
        in_if.last      <= 1'b0;
        in_if.desired   <= 1'b0;
        in_if.accepted  <= 1'b0;
        in_if.sent_kind <= KIND_NONE;
        tb_cid  = 16'd0;
        tb_slot = 8'h00;
        tb_srid = 8'd16;
        tb_lrid = 8'd17;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset ids, only the control id written
        reg_write(REG_FWD_CID, 16'h00c3);
        tb_cid = 16'h00c3;
        simple(OP_SPARE_6);
        simple(OP_SPARE_7);
        simple(OP_REQUEST);
        set_head(ROOT_SLOT, SW_ID, 8'h05, 1);
        send_report(tb_srid, 1);
        simple(OP_CONNECT);
        ctl(OP_SET_WANTED, 1'b1, 1'b0, KIND_NONE);
        simple(OP_REQUEST);
        ctl(OP_OUT_ACCEPT, 1'b0, 1'b0, KIND_FEATURE);
        ctl(OP_OUT_ACCEPT, 1'b1, 1'b1, KIND_SPARE);
        ctl(OP_OUT_ACCEPT, 1'b0, 1'b1, KIND_FEATURE);
        tb_slot = 8'h05;
        set_head(ROOT_SLOT, SW_ID, tb_slot, 4);
        send_report(tb_srid, 4);
        simple(OP_REQUEST);
        ctl(OP_OUT_ACCEPT, 1'b1, 1'b1, KIND_DIVERT);
        set_head(tb_slot, ACK_CODE, 8'hff, 3);
        send_report(tb_lrid, 3);
        set_head(tb_slot, 8'h00, tb_cid[15:8], 5);
        rpt_buf[4] = tb_cid[7:0];
        send_report(tb_lrid, 5);

        // Random, reset ids
        random_phase(55);
        settle(4);

        // Random ids; starts with a long receiver hold-off under full input load
        set_config(16'($urandom_range(1, 65534)), 16'($urandom), 8'($urandom_range(0, 127)),
                   8'($urandom_range(128, 255)));
        hold_req = 1'b1;
        no_gaps  = 1'b1;
        handshake();
        no_gaps  = 1'b0;
        random_phase(90);
        settle(4);

        // Upper extremes, short and long ids equal
        set_config(16'hffff, 16'hffff, 8'hff, 8'hff);
        random_phase(125);
        settle(4);

        // Lower extremes
        set_config(16'h0000, 16'h0000, 8'h00, 8'h00);
        random_phase(160);
        settle(10);

        $display("Run covered %0d events over four register settings, including a long stall.",
                 n_events);
        $display("Checked %0d results: %0d report verdicts, %0d held-state changes.",
                 n_results, n_verdicts, n_held);
        if (fails == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule
